>>> rtl/core/degree_tail_probability_unit_defines.svh
// assertion macros shared by the rtl
`ifndef DEGREE_TAIL_PROBABILITY_UNIT_DEFINES_SVH
`define DEGREE_TAIL_PROBABILITY_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk_i, off while in reset
`define DTP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtp assertion failed");

// next-cycle implication, checked on clk_i, off while in reset
`define DTP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtp assertion failed");

`endif

>>> rtl/core/dtp_pkg.sv
package dtp_pkg;

  localparam int unsigned MaxK     = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProbW    = FracBits + 1;
  localparam int unsigned AddrW    = $clog2(MaxK);
  localparam int unsigned CntW     = $clog2(MaxK + 1);
  localparam int unsigned KW       = 6;
  localparam int unsigned SumW     = ProbW + AddrW;
  localparam int unsigned DiffW    = ProbW + 1;
  localparam int unsigned ProdW    = 2 * DiffW;
  localparam int unsigned ScaledW  = ProdW - FracBits;
  localparam int unsigned NvW      = ScaledW + 1;

  localparam logic [ProbW-1:0] ProbOne = {1'b1, {FracBits{1'b0}}};
  // entry one of the distribution (degree zero) lives at address zero
  localparam logic [AddrW-1:0] DegZeroAddr = '0;
  localparam logic [CntW-1:0]  MaxKCnt     = CntW'(MaxK);

  // apb register map
  localparam logic RegThresholdK = 1'b0;

  typedef enum logic [1:0] {
    StIdle,
    StFold,
    StSum,
    StDone
  } state_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ProbW-1:0] data;
  } dist_wr_t;

endpackage

>>> rtl/core/dtp_dist_store.sv
module dtp_dist_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  dtp_pkg::dist_wr_t           wr_i,
  input  logic [dtp_pkg::AddrW-1:0]   rd_addr_i,
  output logic [dtp_pkg::ProbW-1:0]   rd_data_o
);
  import dtp_pkg::*;

  logic [ProbW-1:0] mem_q [MaxK];
  logic [MaxK-1:0]  valid_q, valid_d;

  // a clear belongs to a newer item than any write still in flight
  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = '0;
    end else if (wr_i.en) begin
      valid_d[wr_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // an unwritten entry reads as the cleared distribution: certainty of degree zero
  always_comb begin
    if (valid_q[rd_addr_i]) begin
      rd_data_o = mem_q[rd_addr_i];
    end else if (rd_addr_i == DegZeroAddr) begin
      rd_data_o = ProbOne;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

>>> rtl/core/degree_tail_probability_unit.sv
// degree tail probability unit
// input stream: one edge of a vertex per transfer; s_tdata_i carries the edge
// probability (16 fraction bits, values above one saturate), s_tuser_i the
// counted and first-edge flags, s_tlast_i marks the vertex's last edge.
// output stream: one transfer per last edge, m_tdata_o holding P(degree >= k).
// apb port: register 0 (byte address 0) holds threshold_k, reset value 1.
// a counted edge walks the 32 stored entries through one shared multiplier,
// one entry per cycle in a two-stage pipe. a last edge then sums k entries
// with one adder, one per cycle, and loads the output register once it is
// free; s_tready_o is high only between items.
// the output register holds a result while the receiver stalls; the next edge
// is still taken and worked on, only the next result waits for the register.
// reset clears the distribution to degree zero with certainty at once, with
// no clearing pass, and sets threshold_k to 1.
`include "degree_tail_probability_unit_defines.svh"

module degree_tail_probability_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // [16:0] edge_prob, rest zero
  input  logic [1:0]  s_tuser_i,   // [0] edge_counts, [1] edge_first
  input  logic        s_tlast_i,   // edge_last
  // output stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // [16:0] tail_prob, rest zero
  // configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import dtp_pkg::*;

  state_e state_q, state_d;

  logic [KW-1:0]   thresh_q;
  logic [CntW-1:0] k_eff;
  logic [CntW-1:0] k_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] idx_m1;
  logic [AddrW-1:0] rd_addr;
  logic [ProbW-1:0] rd_data;
  logic [ProbW-1:0] p_in;
  logic [ProbW-1:0] p_q;
  logic             last_q;
  logic [SumW-1:0]  acc_q;
  logic [ProbW-1:0] prev_q;
  logic [ProbW-1:0] cur_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [DiffW-1:0]  diff;
  logic signed [ScaledW-1:0] scaled;
  logic signed [NvW-1:0]    nv;
  logic [ProbW-1:0] nv_clamped;
  logic             pipe_v_q;
  logic [AddrW-1:0] pipe_addr_q;
  logic [ProbW-1:0] tail;
  logic             m_tvalid_q;
  logic [ProbW-1:0] m_tail_q;
  logic             in_xfer, out_free, cfg_wr;
  logic             fold_en, sum_en, load_out;
  dist_wr_t         dist_wr;

  // configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign prdata_o = (paddr_i[2] == RegThresholdK) ? {{(32 - KW){1'b0}}, thresh_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= KW'(1);
    end else if (cfg_wr && paddr_i[2] == RegThresholdK) begin
      thresh_q <= pwdata_i[KW-1:0];
    end
  end

  assign k_eff = (thresh_q > KW'(MaxK)) ? MaxKCnt : thresh_q[CntW-1:0];
  assign p_in  = (s_tdata_i[ProbW-1:0] > ProbOne) ? ProbOne : s_tdata_i[ProbW-1:0];

  assign in_xfer  = s_tvalid_i && s_tready_o;
  assign out_free = !m_tvalid_q || m_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (s_tuser_i[0]) begin
            state_d = StFold;
          end else if (s_tlast_i) begin
            state_d = (k_eff == '0) ? StDone : StSum;
          end
        end
      end
      StFold: begin
        if (idx_q == MaxKCnt) begin
          if (!last_q) begin
            state_d = StIdle;
          end else begin
            state_d = (k_q == '0) ? StDone : StSum;
          end
        end
      end
      StSum: begin
        if (idx_q == k_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready_o = 1'b0;
    fold_en    = 1'b0;
    sum_en     = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      StIdle: s_tready_o = 1'b1;
      StFold: fold_en    = 1'b1;
      StSum:  sum_en     = 1'b1;
      StDone: load_out   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (in_xfer) begin
      idx_d = CntW'(1);
    end else if (fold_en) begin
      idx_d = (idx_q == MaxKCnt) ? CntW'(1) : idx_q + CntW'(1);
    end else if (sum_en) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= CntW'(1);
      pipe_v_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pipe_v_q <= fold_en;
      if (in_xfer) begin
        last_q <= s_tlast_i;
      end
    end
  end

  // entry j sits at address j-1
  assign idx_m1  = idx_q - CntW'(1);
  assign rd_addr = idx_m1[AddrW-1:0];

  dtp_dist_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (in_xfer && s_tuser_i[1]),
    .wr_i      (dist_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // stage one: difference to the lower entry and the shared multiply
  assign diff = $signed({1'b0, prev_q}) - $signed({1'b0, rd_data});

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      p_q    <= p_in;
      k_q    <= k_eff;
      prev_q <= '0;
      acc_q  <= '0;
    end else begin
      if (fold_en) begin
        prev_q <= rd_data;
      end
      if (sum_en) begin
        acc_q <= acc_q + SumW'(rd_data);
      end
    end
    if (fold_en) begin
      prod_q      <= $signed({1'b0, p_q}) * diff;
      cur_q       <= rd_data;
      pipe_addr_q <= rd_addr;
    end
  end

  // stage two: floor scale, add, clamp to [0, one], write back
  assign scaled = ScaledW'(prod_q >>> FracBits);
  assign nv     = $signed({{(NvW - ProbW){1'b0}}, cur_q}) + $signed({scaled[ScaledW-1], scaled});

  always_comb begin
    if (nv < 0) begin
      nv_clamped = '0;
    end else if (nv > $signed({{(NvW - ProbW){1'b0}}, ProbOne})) begin
      nv_clamped = ProbOne;
    end else begin
      nv_clamped = nv[ProbW-1:0];
    end
  end

  assign dist_wr.en   = pipe_v_q;
  assign dist_wr.addr = pipe_addr_q;
  assign dist_wr.data = nv_clamped;

  assign tail = (acc_q >= SumW'(ProbOne)) ? '0 : ProbOne - acc_q[ProbW-1:0];

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (load_out) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_tail_q <= tail;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {{(24 - ProbW){1'b0}}, m_tail_q};

  `DTP_ASSERT_NOW(a_ready_only_idle, s_tready_o, state_q == StIdle)
  `DTP_ASSERT_NEXT(a_wb_follows_fold, state_q == StFold, pipe_v_q)
  `DTP_ASSERT_NOW(a_fold_idx_range, state_q == StFold, idx_q >= CntW'(1) && idx_q <= MaxKCnt)
  `DTP_ASSERT_NEXT(a_sum_grows, state_q == StSum, acc_q >= $past(acc_q))
  `DTP_ASSERT_NOW(a_result_from_done, $rose(m_tvalid_q), $past(state_q) == StDone)

endmodule
